// ===== src/thmd_pkg.sv =====
// shared types and constants for the text header message deframer
package thmd_pkg;

  localparam int FIELD_BITS  = 16;
  localparam int LENGTH_BITS = 16;
  localparam int ACC_BITS    = (FIELD_BITS > LENGTH_BITS) ? FIELD_BITS : LENGTH_BITS;
  localparam int PROD_BITS   = ACC_BITS + 4;
  localparam int RANK_BITS   = 16;
  localparam int BYTE_BITS   = 8;

  localparam logic [PROD_BITS-1:0] FIELD_LIMIT =
    PROD_BITS'((64'd1 << FIELD_BITS) - 64'd1);
  localparam logic [PROD_BITS-1:0] LENGTH_LIMIT =
    PROD_BITS'((64'd1 << LENGTH_BITS) - 64'd1);

  localparam logic [BYTE_BITS-1:0] CHAR_COLON   = 8'h3A;
  localparam logic [BYTE_BITS-1:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [BYTE_BITS-1:0] CHAR_ZERO    = 8'h30;
  localparam logic [BYTE_BITS-1:0] CHAR_NINE    = 8'h39;

  typedef enum logic [2:0] {
    PH_SRC = 3'd0,
    PH_DST = 3'd1,
    PH_TAG = 3'd2,
    PH_LEN = 3'd3,
    PH_PAY = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ERR_BAD_CHAR  = 2'd0,
    ERR_FIELD     = 2'd1,
    ERR_OVERFLOW  = 2'd2,
    ERR_EARLY_END = 2'd3
  } err_t;

  typedef struct packed {
    logic                 valid;
    kind_t                kind;
    logic [RANK_BITS-1:0] source_rank;
    logic [RANK_BITS-1:0] destination_rank;
    logic [RANK_BITS-1:0] tag_value;
    logic [RANK_BITS-1:0] payload_length;
    logic [BYTE_BITS-1:0] payload_byte;
    logic                 message_last;
    err_t                 error_code;
  } result_t;

endpackage

// ===== src/thmd_parser.sv =====
// header parse state machine, field accumulation and result decode for one byte
module thmd_parser (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           step,
  input  logic [thmd_pkg::BYTE_BITS-1:0] in_byte,
  input  logic                           in_end,
  output thmd_pkg::result_t              res
);

  thmd_pkg::phase_t                   phase, phase_next;
  logic [thmd_pkg::ACC_BITS-1:0]      acc, acc_next;
  logic                               has_digit, has_digit_next;
  logic [thmd_pkg::RANK_BITS-1:0]     held_source, held_source_next;
  logic [thmd_pkg::RANK_BITS-1:0]     held_destination, held_destination_next;
  logic [thmd_pkg::RANK_BITS-1:0]     held_tag, held_tag_next;
  logic [thmd_pkg::RANK_BITS-1:0]     held_length, held_length_next;
  logic [thmd_pkg::RANK_BITS-1:0]     count, count_next;

  thmd_pkg::phase_t                   ph;
  logic                               is_digit;
  logic                               is_colon;
  logic                               is_newline;
  logic                               colon_due;
  logic                               sep_ok;
  logic [thmd_pkg::PROD_BITS-1:0]     limit;
  logic [thmd_pkg::PROD_BITS-1:0]     accum;
  logic                               overflow;
  logic [thmd_pkg::RANK_BITS-1:0]     field_val;
  logic [thmd_pkg::RANK_BITS-1:0]     count_inc;
  logic                               idle_end;

  // unreachable phase codes behave as idle
  always_comb begin
    unique case (phase)
      thmd_pkg::PH_SRC, thmd_pkg::PH_DST, thmd_pkg::PH_TAG,
      thmd_pkg::PH_LEN, thmd_pkg::PH_PAY: ph = phase;
      default: ph = thmd_pkg::PH_SRC;
    endcase
  end

  assign is_digit   = (in_byte >= thmd_pkg::CHAR_ZERO) && (in_byte <= thmd_pkg::CHAR_NINE);
  assign is_colon   = (in_byte == thmd_pkg::CHAR_COLON);
  assign is_newline = (in_byte == thmd_pkg::CHAR_NEWLINE);
  assign colon_due  = (ph == thmd_pkg::PH_SRC) || (ph == thmd_pkg::PH_TAG);
  assign sep_ok     = (is_colon == colon_due) && has_digit;
  assign limit      = (ph == thmd_pkg::PH_LEN) ? thmd_pkg::LENGTH_LIMIT
                                               : thmd_pkg::FIELD_LIMIT;
  assign accum      = thmd_pkg::PROD_BITS'(acc) * thmd_pkg::PROD_BITS'(10)
                    + thmd_pkg::PROD_BITS'(in_byte - thmd_pkg::CHAR_ZERO);
  assign overflow   = accum > limit;
  assign field_val  = thmd_pkg::RANK_BITS'(acc);
  assign count_inc  = count + thmd_pkg::RANK_BITS'(1);
  assign idle_end   = (ph == thmd_pkg::PH_SRC) && !has_digit;

  // next state
  always_comb begin
    phase_next            = ph;
    acc_next              = acc;
    has_digit_next        = has_digit;
    held_source_next      = held_source;
    held_destination_next = held_destination;
    held_tag_next         = held_tag;
    held_length_next      = held_length;
    count_next            = count;
    if (in_end) begin
      phase_next     = thmd_pkg::PH_SRC;
      acc_next       = '0;
      has_digit_next = 1'b0;
      count_next     = '0;
    end else if (ph == thmd_pkg::PH_PAY) begin
      count_next = count_inc;
      if (count_inc == held_length) begin
        phase_next     = thmd_pkg::PH_SRC;
        acc_next       = '0;
        has_digit_next = 1'b0;
        count_next     = '0;
      end
    end else if (is_digit && !overflow) begin
      acc_next       = thmd_pkg::ACC_BITS'(accum);
      has_digit_next = 1'b1;
    end else if ((is_colon || is_newline) && sep_ok) begin
      acc_next       = '0;
      has_digit_next = 1'b0;
      unique case (ph)
        thmd_pkg::PH_SRC: begin
          held_source_next = field_val;
          phase_next       = thmd_pkg::PH_DST;
        end
        thmd_pkg::PH_DST: begin
          held_destination_next = field_val;
          phase_next            = thmd_pkg::PH_TAG;
        end
        thmd_pkg::PH_TAG: begin
          held_tag_next = field_val;
          phase_next    = thmd_pkg::PH_LEN;
        end
        default: begin
          held_length_next = field_val;
          count_next       = '0;
          phase_next       = (field_val == '0) ? thmd_pkg::PH_SRC : thmd_pkg::PH_PAY;
        end
      endcase
    end else begin
      // any error returns to idle
      phase_next     = thmd_pkg::PH_SRC;
      acc_next       = '0;
      has_digit_next = 1'b0;
      count_next     = '0;
    end
  end

  // result decode
  always_comb begin
    res = '0;
    if (in_end) begin
      if (!idle_end) begin
        res.valid      = 1'b1;
        res.kind       = thmd_pkg::KIND_ERROR;
        res.error_code = thmd_pkg::ERR_EARLY_END;
      end
    end else if (ph == thmd_pkg::PH_PAY) begin
      res.valid        = 1'b1;
      res.kind         = thmd_pkg::KIND_PAYLOAD;
      res.payload_byte = in_byte;
      res.message_last = (count_inc == held_length);
    end else if (is_digit) begin
      if (overflow) begin
        res.valid      = 1'b1;
        res.kind       = thmd_pkg::KIND_ERROR;
        res.error_code = thmd_pkg::ERR_OVERFLOW;
      end
    end else if (is_colon || is_newline) begin
      if (!sep_ok) begin
        res.valid      = 1'b1;
        res.kind       = thmd_pkg::KIND_ERROR;
        res.error_code = thmd_pkg::ERR_FIELD;
      end else if (ph == thmd_pkg::PH_LEN) begin
        res.valid            = 1'b1;
        res.kind             = thmd_pkg::KIND_HEADER;
        res.source_rank      = held_source;
        res.destination_rank = held_destination;
        res.tag_value        = held_tag;
        res.payload_length   = field_val;
        res.message_last     = (field_val == '0);
      end
    end else begin
      res.valid      = 1'b1;
      res.kind       = thmd_pkg::KIND_ERROR;
      res.error_code = thmd_pkg::ERR_BAD_CHAR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= thmd_pkg::PH_SRC;
      acc              <= '0;
      has_digit        <= 1'b0;
      held_source      <= '0;
      held_destination <= '0;
      held_tag         <= '0;
      held_length      <= '0;
      count            <= '0;
    end else if (step) begin
      phase            <= phase_next;
      acc              <= acc_next;
      has_digit        <= has_digit_next;
      held_source      <= held_source_next;
      held_destination <= held_destination_next;
      held_tag         <= held_tag_next;
      held_length      <= held_length_next;
      count            <= count_next;
    end
  end

endmodule

// ===== src/text_header_message_deframer_unit.sv =====
// top level: input register, header parser and result register
// an accepted byte is parsed from the input register into the result register
// throughput: one byte per cycle unless a held result stalls the single parse step
// a held result stops the parser; s_tready drops once the input register also holds a byte
// header digits and separators give no transfer; the final separator emits the header
// reset: synchronous, clears both valid flags and returns the parser to idle
module text_header_message_deframer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // rx_byte
  input  logic        s_tuser,   // stream_end
  output logic        m_tvalid,
  input  logic        m_tready,
  // source_rank, destination_rank, tag_value, payload_length, payload_byte,
  // error_code, zero fill
  output logic [79:0] m_tdata,
  output logic [1:0]  m_tuser,   // result_kind
  output logic        m_tlast    // message_last
);

  logic                           in_valid;
  logic [thmd_pkg::BYTE_BITS-1:0] in_byte;
  logic                           in_end;
  logic                           advance;
  thmd_pkg::result_t              res;
  thmd_pkg::result_t              out;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  thmd_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .in_byte (in_byte),
    .in_end  (in_end),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready) begin
      in_byte <= s_tdata;
      in_end  <= s_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= res.valid;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out <= res;
    end
  end

  assign m_tdata = {6'b0, out.error_code, out.payload_byte, out.payload_length,
                    out.tag_value, out.destination_rank, out.source_rank};
  assign m_tuser = out.kind;
  assign m_tlast = out.message_last;

endmodule

// ===== src/thmd_checker.sv =====
// port-level checks for the deframer and their bind to the top level
module thmd_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [79:0] m_tdata,
  input logic [1:0]  m_tuser,
  input logic        m_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output changed while stalled");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

  a_error_not_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == thmd_pkg::KIND_ERROR) |-> !m_tlast && (m_tdata[71:0] == '0))
    else $error("error transfer carries data or last");

  a_empty_header_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == thmd_pkg::KIND_HEADER)
      |-> (m_tlast == (m_tdata[63:48] == '0)) && (m_tdata[73:64] == '0))
    else $error("header last flag does not match zero length");

  a_payload_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == thmd_pkg::KIND_PAYLOAD)
      |-> (m_tdata[63:0] == '0) && (m_tdata[73:72] == '0))
    else $error("payload transfer carries header or error fields");

endmodule

bind text_header_message_deframer_unit thmd_checker u_thmd_checker (.*);
